@@ sv/glob_pattern_match_unit_defines.svh @@
// Assertion macros for the glob matcher.
// Used by the files that carry concurrent checks; no other dependencies.
`ifndef GLOB_PATTERN_MATCH_UNIT_DEFINES_SVH
`define GLOB_PATTERN_MATCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("glob matcher check failed");
`define GPM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("glob matcher check failed");
`else
`define GPM_ASSERT(lbl, clk, rstn, prop)
`define GPM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/gpm_pkg.sv @@
// Shared types, constants and helpers of the glob matcher.
// No dependencies.
package gpm_pkg;

  localparam int unsigned PAT_DEPTH = 64;
  localparam int unsigned TXT_DEPTH = 256;
  localparam int unsigned PAT_AW = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int unsigned TXT_AW = (TXT_DEPTH > 1) ? $clog2(TXT_DEPTH) : 1;
  localparam int unsigned PAT_LW = $clog2(PAT_DEPTH + 1);
  localparam int unsigned TXT_LW = $clog2(TXT_DEPTH + 1);
  localparam int unsigned PE_W = 9;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_RBR = 8'h5D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DASH = 8'h2D;

  typedef enum logic [1:0] {
    OP_PAT  = 2'd0,
    OP_TXT  = 2'd1,
    OP_RUN  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_CHK      = 15'b000000000000010,
    S_CHK_D    = 15'b000000000000100,
    S_SET_NEG  = 15'b000000000001000,
    S_SET_NEGD = 15'b000000000010000,
    S_SET_RB   = 15'b000000000100000,
    S_SET_RBD  = 15'b000000001000000,
    S_SET_LOOP = 15'b000000010000000,
    S_SET_LD   = 15'b000000100000000,
    S_SET_LD2  = 15'b000001000000000,
    S_M_TOP    = 15'b000010000000000,
    S_M_D      = 15'b000100000000000,
    S_TAIL     = 15'b001000000000000,
    S_TAIL_D   = 15'b010000000000000,
    S_RES      = 15'b100000000000000
  } state_e;

  typedef struct packed {
    logic              pat_we;
    logic [PAT_AW-1:0] pat_waddr;
    logic [PE_W-1:0]   pat_wdata;
    logic [PAT_AW-1:0] pat_raddr_a;
    logic [PAT_AW-1:0] pat_raddr_b;
    logic              txt_we;
    logic [TXT_AW-1:0] txt_waddr;
    logic [7:0]        txt_wdata;
    logic [TXT_AW-1:0] txt_raddr;
  } mem_req_t;

  function automatic logic is_sp(input logic [PE_W-1:0] e, input logic [7:0] c);
    return !e[8] && (e[7:0] == c);
  endfunction

endpackage

@@ sv/gpm_if.sv @@
// Handshake channels of the glob matcher: input items and result items.
// Depends on gpm_pkg.
interface gpm_in_if import gpm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_value;
  logic       is_quoted;

  modport source (output valid, op, byte_value, is_quoted, input ready);
  modport sink (input valid, op, byte_value, is_quoted, output ready);
endinterface

interface gpm_out_if import gpm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       matched;

  modport source (output valid, status, matched, input ready);
  modport sink (input valid, status, matched, output ready);
endinterface

@@ sv/glob_pattern_match_unit.sv @@
// Top level of the glob matcher: pattern and text memories plus sequencer.
// Depends on gpm_pkg, gpm_if, gpm_ram and gpm_ctrl.
//
//   channel  dir  payload                        transfer
//   in_i     in   op, byte_value, is_quoted      valid && ready
//   out_o    out  status, matched                valid && ready
//
// Load items are accepted back to back while the sequencer is idle. A run
// steps through the bracket check over each pattern entry, then the
// matching walk (backtracks too) and the trailing stars; each bracket set
// is read from its opening bracket through every member to the closing
// bracket, and every memory read is registered. The result is then handed
// to the output register. Reset clears lengths, overflow and control;
// memory contents are left as they are. A result waits in the
// output register while loads continue; a new result waits until it is taken.
module glob_pattern_match_unit import gpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gpm_in_if.sink    in_i,
  gpm_out_if.source out_o
);

  mem_req_t        mem_req;
  logic [PE_W-1:0] pat_a, pat_b;
  logic [7:0]      txt_rd;

  gpm_ram #(.W(PE_W), .D(PAT_DEPTH)) u_pat_a (
    .clk_i   (clk_i),
    .we_i    (mem_req.pat_we),
    .waddr_i (mem_req.pat_waddr),
    .wdata_i (mem_req.pat_wdata),
    .raddr_i (mem_req.pat_raddr_a),
    .rdata_o (pat_a)
  );

  gpm_ram #(.W(PE_W), .D(PAT_DEPTH)) u_pat_b (
    .clk_i   (clk_i),
    .we_i    (mem_req.pat_we),
    .waddr_i (mem_req.pat_waddr),
    .wdata_i (mem_req.pat_wdata),
    .raddr_i (mem_req.pat_raddr_b),
    .rdata_o (pat_b)
  );

  gpm_ram #(.W(8), .D(TXT_DEPTH)) u_txt (
    .clk_i   (clk_i),
    .we_i    (mem_req.txt_we),
    .waddr_i (mem_req.txt_waddr),
    .wdata_i (mem_req.txt_wdata),
    .raddr_i (mem_req.txt_raddr),
    .rdata_o (txt_rd)
  );

  gpm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_req_o (mem_req),
    .pat_a_i   (pat_a),
    .pat_b_i   (pat_b),
    .txt_i     (txt_rd)
  );

endmodule

@@ sv/gpm_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module gpm_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/gpm_ctrl.sv @@
// Sequencer of the glob matcher: loads, bracket check, matching walk.
// Depends on gpm_pkg, gpm_if and the assertion macros.
`include "glob_pattern_match_unit_defines.svh"
module gpm_ctrl import gpm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  gpm_in_if.sink          in_i,
  gpm_out_if.source       out_o,
  output mem_req_t        mem_req_o,
  input  logic [PE_W-1:0] pat_a_i,
  input  logic [PE_W-1:0] pat_b_i,
  input  logic [7:0]      txt_i
);

  state_e state_q, state_d;
  logic [PAT_LW-1:0] plen_q, plen_d, p_q, p_d, star_p_q, star_p_d, sp_q, sp_d;
  logic [TXT_LW-1:0] tlen_q, tlen_d, t_q, t_d, star_t_q, star_t_d;
  logic ovf_q, ovf_d, have_star_q, have_star_d, chk_q, chk_d;
  logic neg_q, neg_d, hit_q, hit_d, member_q, member_d;
  logic [7:0] v_q, v_d;
  logic [PE_W-1:0] e0_q, e0_d, e1_q, e1_d;
  logic [1:0] res_st_q, res_st_d, out_st_q, out_st_d;
  logic res_m_q, res_m_d, out_m_q, out_m_d, out_v_q, out_v_d;

  logic in_acc, pat_ok, txt_ok, out_free;
  logic [PAT_LW:0] sp2;
  logic set_done, set_bad, set_hit, fail;
  logic [PAT_LW-1:0] set_next;

  assign in_acc   = in_i.valid && in_i.ready;
  assign pat_ok   = plen_q < PAT_LW'(PAT_DEPTH);
  assign txt_ok   = tlen_q < TXT_LW'(TXT_DEPTH);
  assign out_free = !out_v_q || out_o.ready;
  assign sp2      = {1'b0, sp_q} + (PAT_LW + 1)'(2);

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_v_q;
  assign out_o.status  = out_st_q;
  assign out_o.matched = out_m_q;

  always_comb begin
    mem_req_o             = '0;
    mem_req_o.pat_we      = in_acc && (in_i.op == OP_PAT) && pat_ok;
    mem_req_o.pat_waddr   = plen_q[PAT_AW-1:0];
    mem_req_o.pat_wdata   = {in_i.is_quoted, in_i.byte_value};
    mem_req_o.txt_we      = in_acc && (in_i.op == OP_TXT) && txt_ok;
    mem_req_o.txt_waddr   = tlen_q[TXT_AW-1:0];
    mem_req_o.txt_wdata   = in_i.byte_value;
    mem_req_o.txt_raddr   = t_q[TXT_AW-1:0];
    mem_req_o.pat_raddr_a = p_q[PAT_AW-1:0];
    mem_req_o.pat_raddr_b = PAT_AW'(sp_q + PAT_LW'(1));
    if (state_q == S_SET_NEG || state_q == S_SET_RB || state_q == S_SET_LOOP) begin
      mem_req_o.pat_raddr_a = sp_q[PAT_AW-1:0];
    end else if (state_q == S_SET_LD) begin
      mem_req_o.pat_raddr_a = sp2[PAT_AW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    plen_d = plen_q; tlen_d = tlen_q; ovf_d = ovf_q;
    p_d = p_q; t_d = t_q; star_p_d = star_p_q; star_t_d = star_t_q;
    have_star_d = have_star_q; chk_d = chk_q; sp_d = sp_q;
    neg_d = neg_q; hit_d = hit_q; member_d = member_q; v_d = v_q;
    e0_d = e0_q; e1_d = e1_q;
    res_st_d = res_st_q; res_m_d = res_m_q;
    out_st_d = out_st_q; out_m_d = out_m_q;
    out_v_d = out_v_q && !out_o.ready;
    set_done = 1'b0; set_bad = 1'b0; set_hit = 1'b0; set_next = sp_q;
    fail = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.op)
            OP_PAT: begin
              if (pat_ok) plen_d = plen_q + PAT_LW'(1);
              else ovf_d = 1'b1;
            end
            OP_TXT: begin
              if (txt_ok) tlen_d = tlen_q + TXT_LW'(1);
              else ovf_d = 1'b1;
            end
            OP_RUN: begin
              if (ovf_q) begin
                res_st_d = ST_OVF;
                res_m_d  = 1'b0;
                state_d  = S_RES;
              end else begin
                p_d     = '0;
                chk_d   = 1'b1;
                state_d = S_CHK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (p_q >= plen_q) begin
          p_d = '0; t_d = '0; have_star_d = 1'b0; chk_d = 1'b0;
          state_d = S_M_TOP;
        end else begin
          state_d = S_CHK_D;
        end
      end
      S_CHK_D: begin
        if (is_sp(pat_a_i, CH_LBR)) begin
          sp_d = p_q + PAT_LW'(1); v_d = '0;
          neg_d = 1'b0; hit_d = 1'b0; member_d = 1'b0;
          state_d = S_SET_NEG;
        end else begin
          p_d = p_q + PAT_LW'(1);
          state_d = S_CHK;
        end
      end
      S_SET_NEG: state_d = S_SET_NEGD;
      S_SET_NEGD: begin
        if (sp_q < plen_q && (is_sp(pat_a_i, CH_BANG) || is_sp(pat_a_i, CH_CARET))) begin
          neg_d = 1'b1;
          sp_d  = sp_q + PAT_LW'(1);
        end
        state_d = S_SET_RB;
      end
      S_SET_RB: state_d = S_SET_RBD;
      S_SET_RBD: begin
        if (sp_q < plen_q && is_sp(pat_a_i, CH_RBR)) begin
          hit_d    = (v_q == CH_RBR);
          member_d = 1'b1;
          sp_d     = sp_q + PAT_LW'(1);
        end
        state_d = S_SET_LOOP;
      end
      S_SET_LOOP: begin
        if (sp_q >= plen_q) begin
          set_bad = 1'b1;
        end else begin
          state_d = S_SET_LD;
        end
      end
      S_SET_LD: begin
        e0_d = pat_a_i;
        e1_d = pat_b_i;
        state_d = S_SET_LD2;
      end
      S_SET_LD2: begin
        if (member_q && is_sp(e0_q, CH_RBR)) begin
          set_done = 1'b1;
          set_hit  = neg_q ^ hit_q;
          set_next = sp_q + PAT_LW'(1);
        end else begin
          member_d = 1'b1;
          state_d  = S_SET_LOOP;
          if (sp2 < {1'b0, plen_q} && is_sp(e1_q, CH_DASH) && !is_sp(pat_a_i, CH_RBR)) begin
            if (e0_q[7:0] > pat_a_i[7:0]) begin
              set_bad = 1'b1;
            end else begin
              if (v_q >= e0_q[7:0] && v_q <= pat_a_i[7:0]) hit_d = 1'b1;
              sp_d = PAT_LW'(sp2 + (PAT_LW + 1)'(1));
            end
          end else begin
            if (e0_q[7:0] == v_q) hit_d = 1'b1;
            sp_d = sp_q + PAT_LW'(1);
          end
        end
      end
      S_M_TOP: begin
        if (t_q >= tlen_q) state_d = S_TAIL;
        else state_d = S_M_D;
      end
      S_M_D: begin
        state_d = S_M_TOP;
        if (p_q < plen_q) begin
          if (is_sp(pat_a_i, CH_STAR)) begin
            have_star_d = 1'b1;
            star_p_d = p_q; star_t_d = t_q;
            p_d = p_q + PAT_LW'(1);
          end else if (is_sp(pat_a_i, CH_QMARK)) begin
            p_d = p_q + PAT_LW'(1);
            t_d = t_q + TXT_LW'(1);
          end else if (is_sp(pat_a_i, CH_LBR)) begin
            sp_d = p_q + PAT_LW'(1); v_d = txt_i;
            neg_d = 1'b0; hit_d = 1'b0; member_d = 1'b0;
            state_d = S_SET_NEG;
          end else if (pat_a_i[7:0] == txt_i) begin
            p_d = p_q + PAT_LW'(1);
            t_d = t_q + TXT_LW'(1);
          end else begin
            fail = 1'b1;
          end
        end else begin
          fail = 1'b1;
        end
      end
      S_TAIL: begin
        if (p_q >= plen_q) begin
          res_st_d = ST_OK;
          res_m_d  = (p_q == plen_q);
          state_d  = S_RES;
        end else begin
          state_d = S_TAIL_D;
        end
      end
      S_TAIL_D: begin
        if (is_sp(pat_a_i, CH_STAR)) begin
          p_d = p_q + PAT_LW'(1);
          state_d = S_TAIL;
        end else begin
          res_st_d = ST_OK;
          res_m_d  = 1'b0;
          state_d  = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_v_d  = 1'b1;
          out_st_d = res_st_q;
          out_m_d  = res_m_q;
          plen_d = '0; tlen_d = '0; ovf_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (set_bad) begin
      res_st_d = ST_BAD;
      res_m_d  = 1'b0;
      state_d  = S_RES;
    end else if (set_done) begin
      if (chk_q) begin
        p_d = set_next;
        state_d = S_CHK;
      end else if (set_hit) begin
        p_d = set_next;
        t_d = t_q + TXT_LW'(1);
        state_d = S_M_TOP;
      end else begin
        fail = 1'b1;
      end
    end

    if (fail) begin
      if (!have_star_q) begin
        res_st_d = ST_OK;
        res_m_d  = 1'b0;
        state_d  = S_RES;
      end else begin
        p_d = star_p_q + PAT_LW'(1);
        star_t_d = star_t_q + TXT_LW'(1);
        t_d = star_t_q + TXT_LW'(1);
        state_d = S_M_TOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plen_q  <= '0;
      tlen_q  <= '0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      plen_q  <= plen_d;
      tlen_q  <= tlen_d;
      ovf_q   <= ovf_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; t_q <= t_d; star_p_q <= star_p_d; star_t_q <= star_t_d;
    have_star_q <= have_star_d; chk_q <= chk_d; sp_q <= sp_d;
    neg_q <= neg_d; hit_q <= hit_d; member_q <= member_d; v_q <= v_d;
    e0_q <= e0_d; e1_q <= e1_d;
    res_st_q <= res_st_d; res_m_q <= res_m_d;
    out_st_q <= out_st_d; out_m_q <= out_m_d;
  end

  `GPM_ASSERT(a_plen_bound, clk_i, rst_ni, plen_q <= PAT_LW'(PAT_DEPTH))
  `GPM_ASSERT(a_tlen_bound, clk_i, rst_ni, tlen_q <= TXT_LW'(TXT_DEPTH))
  `GPM_ASSERT(a_clear_after_run, clk_i, rst_ni, (state_q == S_RES && out_free) |=> (plen_q == '0 && tlen_q == '0 && !ovf_q))
  `GPM_ASSERT(a_match_ok_only, clk_i, rst_ni, (out_v_q && out_m_q) |-> (out_st_q == ST_OK))
  `GPM_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (state_q == S_IDLE || !rst_ni))

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for glob_pattern_match_unit: loads patterns and texts, runs matches.
// Checks every result against its own glob matcher model; uses gpm_pkg and gpm_if.
`timescale 1ns / 1ps
module tb_top;
  import gpm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 950;

  typedef struct {
    status_e st;
    logic    matched;
  } verdict_t;

  typedef struct {
    status_e st;
    bit      hit;
    int      nxt;
  } set_res_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   cycles;
  int   items_sent;
  int   sink_wait;
  int   hold_left;
  bit   no_gaps;

  verdict_t verdict_q[$];

  logic [8:0] pat_mem[PAT_DEPTH];
  logic [7:0] txt_mem[TXT_DEPTH];
  int         pat_len;
  int         txt_len;
  bit         ovf;

  gpm_in_if  in_if();
  gpm_out_if out_if();

  glob_pattern_match_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk = ~clk;

  function automatic bit unq(int i, logic [7:0] c);
    return !pat_mem[i][8] && (pat_mem[i][7:0] == c);
  endfunction

  function automatic set_res_t eval_bracket(int open, logic [7:0] v);
    set_res_t r;
    int p;
    bit neg, hit, member;
    logic [7:0] lo, hi;
    r.st = ST_BAD;
    r.hit = 0;
    r.nxt = 0;
    p = open + 1;
    neg = 0;
    hit = 0;
    member = 0;
    if (p < pat_len && (unq(p, CH_BANG) || unq(p, CH_CARET))) begin
      neg = 1;
      p++;
    end
    if (p < pat_len && unq(p, CH_RBR)) begin
      hit = (v == CH_RBR);
      member = 1;
      p++;
    end
    while (p < pat_len) begin
      if (member && unq(p, CH_RBR)) begin
        r.st = ST_OK;
        r.hit = neg ? !hit : hit;
        r.nxt = p + 1;
        return r;
      end
      member = 1;
      if (p + 2 < pat_len && unq(p + 1, CH_DASH) && !unq(p + 2, CH_RBR)) begin
        lo = pat_mem[p][7:0];
        hi = pat_mem[p + 2][7:0];
        if (lo > hi) return r;
        if (v >= lo && v <= hi) hit = 1;
        p += 3;
      end else begin
        if (pat_mem[p][7:0] == v) hit = 1;
        p++;
      end
    end
    return r;
  endfunction

  function automatic verdict_t glob_match();
    verdict_t res;
    set_res_t sr;
    int p, t, star_p, star_t;
    bit have_star, ok;
    int nx;
    res.st = ST_OK;
    res.matched = 0;
    p = 0;
    while (p < pat_len) begin
      if (unq(p, CH_LBR)) begin
        sr = eval_bracket(p, 8'h00);
        if (sr.st != ST_OK) begin
          res.st = sr.st;
          return res;
        end
        p = sr.nxt;
      end else begin
        p++;
      end
    end
    p = 0;
    t = 0;
    star_p = 0;
    star_t = 0;
    have_star = 0;
    while (t < txt_len) begin
      if (p < pat_len && unq(p, CH_STAR)) begin
        have_star = 1;
        star_p = p;
        star_t = t;
        p++;
        continue;
      end
      if (p < pat_len) begin
        if (unq(p, CH_QMARK)) begin
          ok = 1;
          nx = p + 1;
        end else if (unq(p, CH_LBR)) begin
          sr = eval_bracket(p, txt_mem[t]);
          if (sr.st != ST_OK) begin
            res.st = sr.st;
            return res;
          end
          ok = sr.hit;
          nx = sr.nxt;
        end else begin
          ok = (pat_mem[p][7:0] == txt_mem[t]);
          nx = p + 1;
        end
        if (ok) begin
          p = nx;
          t++;
          continue;
        end
      end
      if (!have_star) return res;
      p = star_p + 1;
      star_t++;
      t = star_t;
    end
    while (p < pat_len && unq(p, CH_STAR)) p++;
    res.matched = (p == pat_len);
    return res;
  endfunction

  function automatic void predict_item(op_e op, logic [7:0] b, logic q);
    verdict_t v;
    case (op)
      OP_PAT: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = {q, b};
          pat_len++;
        end else begin
          ovf = 1;
        end
      end
      OP_TXT: begin
        if (txt_len < TXT_DEPTH) begin
          txt_mem[txt_len] = b;
          txt_len++;
        end else begin
          ovf = 1;
        end
      end
      OP_RUN: begin
        if (ovf) begin
          v.st = ST_OVF;
          v.matched = 0;
        end else begin
          v = glob_match();
        end
        verdict_q.push_back(v);
        pat_len = 0;
        txt_len = 0;
        ovf = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic send_item(op_e op, logic [7:0] b, logic q);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_if.op = op;
    in_if.byte_value = b;
    in_if.is_quoted = q;
    in_if.valid = 1;
    do @(posedge clk); while (!in_if.ready);
    predict_item(op, b, q);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_pat(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_PAT, s[i], 1'b0);
  endtask

  task automatic load_txt(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_TXT, s[i], 1'b0);
  endtask

  task automatic glob_case(string pat, string txt);
    load_pat(pat);
    load_txt(txt);
    send_item(OP_RUN, 8'h00, 1'b0);
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_sequence();
    logic [8:0] pq[$];
    logic [7:0] tq[$];
    logic [7:0] c, lo, hi;
    string specials;
    int ntok, kind, nm;
    bit neg;
    specials = "*?[]!^-";
    ntok = $urandom_range(0, 6);
    for (int k = 0; k < ntok && pq.size() < 50; k++) begin
      kind = $urandom_range(0, 9);
      c = 8'("a" + $urandom_range(0, 4));
      if (kind <= 3) begin
        pq.push_back({1'b0, c});
        tq.push_back(c);
      end else if (kind == 4) begin
        pq.push_back({1'b0, CH_QMARK});
        tq.push_back(c);
      end else if (kind == 5) begin
        pq.push_back({1'b0, CH_STAR});
        repeat ($urandom_range(0, 3)) tq.push_back(8'("a" + $urandom_range(0, 4)));
      end else if (kind == 6) begin
        c = specials[$urandom_range(0, 6)];
        pq.push_back({1'b1, c});
        tq.push_back(c);
      end else if (kind <= 8) begin
        neg = ($urandom_range(0, 3) == 0);
        pq.push_back({1'b0, CH_LBR});
        if (neg) pq.push_back({1'b0, $urandom_range(0, 1) ? CH_BANG : CH_CARET});
        if ($urandom_range(0, 4) == 0) begin
          pq.push_back({1'b0, CH_RBR});
          c = CH_RBR;
        end
        nm = $urandom_range(1, 2);
        for (int m = 0; m < nm; m++) begin
          lo = 8'("a" + $urandom_range(0, 4));
          if ($urandom_range(0, 1)) begin
            hi = 8'(lo + $urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
              c = lo;
              lo = 8'(hi + 8'd1);
              hi = c;
            end
            pq.push_back({1'b0, lo});
            pq.push_back({1'b0, CH_DASH});
            pq.push_back({1'b0, hi});
          end else begin
            pq.push_back({1'b0, lo});
          end
          if (m == 0) c = lo;
        end
        if ($urandom_range(0, 14) != 0) pq.push_back({1'b0, CH_RBR});
        tq.push_back(neg ? "z" : c);
      end else begin
        c = 8'($urandom_range(0, 255));
        pq.push_back({1'($urandom_range(0, 1)), c});
        tq.push_back(c);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: if (tq.size() > 0) tq[$urandom_range(0, tq.size() - 1)] = 8'($urandom_range(0, 255));
        1: if (tq.size() > 0) tq.delete($urandom_range(0, tq.size() - 1));
        default: tq.push_back(8'("a" + $urandom_range(0, 4)));
      endcase
    end
    foreach (pq[i]) send_item(OP_PAT, pq[i][7:0], pq[i][8]);
    foreach (tq[i]) send_item(OP_TXT, tq[i], 1'b0);
    send_item(OP_RUN, 8'h00, 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_item(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed();
    glob_case("", "");
    glob_case("", "a");
    glob_case("*", "");
    glob_case("a**", "a");
    glob_case("a?c", "abc");
    glob_case("*b*d", "abcbd");
    glob_case("[!a]x", "bx");
    glob_case("[^a]", "a");
    glob_case("[]a]", "]");
    glob_case("[a-c]", "b");
    glob_case("[c-a]", "b");
    glob_case("ab[c", "abc");
    glob_case("[a-]", "-");
    send_item(OP_PAT, CH_STAR, 1'b1);
    send_item(OP_TXT, CH_STAR, 1'b0);
    send_item(OP_RUN, 8'h00, 1'b0);
    send_item(OP_PAT, CH_LBR, 1'b1);
    send_item(OP_TXT, CH_LBR, 1'b0);
    send_item(OP_RUN, 8'h00, 1'b0);
    send_item(OP_PAT, 8'hFF, 1'b0);
    send_item(OP_PAT, 8'h00, 1'b1);
    send_item(OP_TXT, 8'hFF, 1'b0);
    send_item(OP_TXT, 8'h00, 1'b0);
    send_item(OP_NONE, 8'hFF, 1'b1);
    send_item(OP_RUN, 8'h00, 1'b0);
    send_item(OP_NONE, 8'h00, 1'b0);
    send_item(OP_RUN, 8'h00, 1'b0);
    repeat (PAT_DEPTH + 1) send_item(OP_PAT, "a", 1'b0);
    send_item(OP_RUN, 8'h00, 1'b0);
    repeat (PAT_DEPTH) send_item(OP_PAT, "?", 1'b0);
    repeat (PAT_DEPTH) send_item(OP_TXT, "q", 1'b0);
    send_item(OP_RUN, 8'h00, 1'b0);
    send_item(OP_PAT, CH_STAR, 1'b0);
    repeat (TXT_DEPTH + 1) send_item(OP_TXT, "b", 1'b0);
    send_item(OP_RUN, 8'h00, 1'b0);
  endtask

  task automatic test_random(int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_sequence();
    end
  endtask

  task automatic test_no_idle();
    no_gaps = 1;
    repeat (10) send_sequence();
    no_gaps = 0;
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    repeat (6) send_sequence();
  endtask

  task automatic test_drain_pause();
    repeat (3) send_sequence();
    in_if.valid = 0;
    wait_drained();
    repeat (3) send_sequence();
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    errors = 0;
    items_sent = 0;
    no_gaps = 0;
    pat_len = 0;
    txt_len = 0;
    ovf = 0;
    in_if.valid = 0;
    in_if.op = OP_NONE;
    in_if.byte_value = 0;
    in_if.is_quoted = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(ITEM_TARGET / 8);
    test_no_idle();
    test_backpressure();
    test_drain_pause();
    test_random(ITEM_TARGET - items_sent);
    in_if.valid = 0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    out_if.ready = 0;
    hold_left = 0;
    sink_wait = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 0;
        hold_left--;
      end else if (sink_wait > 0) begin
        out_if.ready = 0;
        sink_wait--;
      end else begin
        out_if.ready = 1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_if.valid && out_if.ready) begin
      sink_wait = no_gaps ? 0 : $urandom_range(0, 15);
      if (verdict_q.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        v = verdict_q.pop_front();
        if (out_if.status !== v.st)
          report($sformatf("status %0d, expected %0d", out_if.status, v.st));
        if (out_if.matched !== v.matched)
          report($sformatf("matched %0d, expected %0d", out_if.matched, v.matched));
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
